[hdl/mieu_pkg.sv]
// Shared types, opcode and function codes for the MIPS integer execute unit.
package mieu_pkg;

    localparam int REG_COUNT = 32;

    typedef logic [31:0] word_t;
    typedef logic [4:0]  reg_idx_t;

    // Program counter after reset
    localparam word_t START_ADDR_RESET = 32'h0040_0000;

    // Primary opcodes
    localparam logic [5:0] OP_SPECIAL  = 6'h00;
    localparam logic [5:0] OP_REGIMM   = 6'h01;
    localparam logic [5:0] OP_J        = 6'h02;
    localparam logic [5:0] OP_JAL      = 6'h03;
    localparam logic [5:0] OP_BEQ      = 6'h04;
    localparam logic [5:0] OP_BNE      = 6'h05;
    localparam logic [5:0] OP_BLEZ     = 6'h06;
    localparam logic [5:0] OP_BGTZ     = 6'h07;
    localparam logic [5:0] OP_ADDI     = 6'h08;
    localparam logic [5:0] OP_SLTI     = 6'h0A;
    localparam logic [5:0] OP_ANDI     = 6'h0C;
    localparam logic [5:0] OP_ORI      = 6'h0D;
    localparam logic [5:0] OP_XORI     = 6'h0E;
    localparam logic [5:0] OP_LUI      = 6'h0F;
    localparam logic [5:0] OP_SPECIAL2 = 6'h1C;

    // SPECIAL function codes
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SLLV    = 6'h04;
    localparam logic [5:0] FN_SRLV    = 6'h06;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_SLT     = 6'h2A;

    // SPECIAL2 function code
    localparam logic [5:0] FN_MUL = 6'h02;

    // REGIMM rt codes
    localparam reg_idx_t RT_BLTZ = 5'd0;
    localparam reg_idx_t RT_BGEZ = 5'd1;

    localparam reg_idx_t REG_ZERO = 5'd0;
    localparam reg_idx_t REG_RA   = 5'd31;

    localparam word_t JUMP_REGION_MASK = 32'hF000_0000;

    // Register file write port
    typedef struct packed {
        logic     en;
        reg_idx_t index;
        word_t    value;
    } rf_write_t;

    // Outcome of one instruction
    typedef struct packed {
        word_t    next_pc;
        logic     reg_write;
        reg_idx_t write_index;
        word_t    write_value;
        logic     syscall_seen;
        logic     unknown_op;
    } exec_result_t;

endpackage

[hdl/mieu_regfile.sv]
// Register file with registered read, per-entry valid bits and write forwarding.
module mieu_regfile (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  mieu_pkg::reg_idx_t  rs_idx,
    input  mieu_pkg::reg_idx_t  rt_idx,
    input  mieu_pkg::rf_write_t wr,
    output mieu_pkg::word_t     rs_value,
    output mieu_pkg::word_t     rt_value
);
    import mieu_pkg::*;

    word_t                regs_mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    word_t                rs_data_reg;
    word_t                rt_data_reg;
    word_t                fwd_value_reg;
    logic                 rs_vld_reg;
    logic                 rt_vld_reg;
    logic                 rs_fwd_reg;
    logic                 rt_fwd_reg;

    // Write the memory and capture read data
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            regs_mem[wr.index] <= wr.value;
        end
        if (rd_en)
        begin
            rs_data_reg   <= regs_mem[rs_idx];
            rt_data_reg   <= regs_mem[rt_idx];
            fwd_value_reg <= wr.value;
        end
    end

    // Track written entries and same-cycle writes to the read addresses
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rs_vld_reg <= 1'b0;
            rt_vld_reg <= 1'b0;
            rs_fwd_reg <= 1'b0;
            rt_fwd_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.index] <= 1'b1;
            end
            if (rd_en)
            begin
                rs_vld_reg <= valid_reg[rs_idx];
                rt_vld_reg <= valid_reg[rt_idx];
                rs_fwd_reg <= wr.en && (wr.index == rs_idx);
                rt_fwd_reg <= wr.en && (wr.index == rt_idx);
            end
        end
    end

    // Never-written entries, register zero included, read as zero
    assign rs_value = rs_fwd_reg ? fwd_value_reg : (rs_vld_reg ? rs_data_reg : '0);
    assign rt_value = rt_fwd_reg ? fwd_value_reg : (rt_vld_reg ? rt_data_reg : '0);

endmodule

[hdl/mieu_exec.sv]
// Instruction decode, ALU, branch and jump resolution for one instruction.
module mieu_exec (
    input  mieu_pkg::word_t        instr,
    input  mieu_pkg::word_t        pc,
    input  mieu_pkg::word_t        rs_value,
    input  mieu_pkg::word_t        rt_value,
    output mieu_pkg::exec_result_t res
);
    import mieu_pkg::*;

    logic [5:0] op;
    logic [5:0] fn;
    reg_idx_t   rt;
    reg_idx_t   rd;
    logic [4:0] sh;
    logic [15:0] imm;
    word_t      imm_sext;
    word_t      imm_zext;
    word_t      seq_pc;
    word_t      br_target;
    word_t      j_target;
    word_t      product;
    logic       lt_reg;
    logic       lt_imm;
    logic       rs_neg;
    logic       rs_zero;

    // Field extraction and shared datapath
    assign op        = instr[31:26];
    assign rt        = instr[20:16];
    assign rd        = instr[15:11];
    assign sh        = instr[10:6];
    assign fn        = instr[5:0];
    assign imm       = instr[15:0];
    assign imm_sext  = {{16{imm[15]}}, imm};
    assign imm_zext  = {16'h0000, imm};
    assign seq_pc    = pc + 32'd4;
    assign br_target = seq_pc + {imm_sext[29:0], 2'b00};
    assign j_target  = (seq_pc & JUMP_REGION_MASK) | {4'h0, instr[25:0], 2'b00};
    assign product   = rs_value * rt_value;
    assign lt_reg    = $signed(rs_value) < $signed(rt_value);
    assign lt_imm    = $signed(rs_value) < $signed(imm_sext);
    assign rs_neg    = rs_value[31];
    assign rs_zero   = (rs_value == '0);

    // Decode and select the outcome
    always_comb
    begin
        res              = '0;
        res.next_pc      = seq_pc;
        unique case (op)
            OP_SPECIAL:
            begin
                res.reg_write   = 1'b1;
                res.write_index = rd;
                unique case (fn)
                    FN_ADD:  res.write_value = rs_value + rt_value;
                    FN_SUB:  res.write_value = rs_value - rt_value;
                    FN_AND:  res.write_value = rs_value & rt_value;
                    FN_OR:   res.write_value = rs_value | rt_value;
                    FN_XOR:  res.write_value = rs_value ^ rt_value;
                    FN_SLLV: res.write_value = rt_value << rs_value[4:0];
                    FN_SRLV: res.write_value = rt_value >> rs_value[4:0];
                    FN_SLT:  res.write_value = {31'd0, lt_reg};
                    FN_SLL:  res.write_value = rt_value << sh;
                    FN_SRL:  res.write_value = rt_value >> sh;
                    FN_JR:
                    begin
                        res.reg_write = 1'b0;
                        res.next_pc   = rs_value;
                    end
                    FN_SYSCALL:
                    begin
                        res.reg_write    = 1'b0;
                        res.syscall_seen = 1'b1;
                    end
                    default:
                    begin
                        res.reg_write  = 1'b0;
                        res.unknown_op = 1'b1;
                    end
                endcase
            end
            OP_SPECIAL2:
            begin
                if (fn == FN_MUL)
                begin
                    res.reg_write   = 1'b1;
                    res.write_index = rd;
                    res.write_value = product;
                end
                else
                begin
                    res.unknown_op = 1'b1;
                end
            end
            OP_ADDI:
            begin
                res.reg_write   = 1'b1;
                res.write_index = rt;
                res.write_value = rs_value + imm_sext;
            end
            OP_ANDI:
            begin
                res.reg_write   = 1'b1;
                res.write_index = rt;
                res.write_value = rs_value & imm_zext;
            end
            OP_ORI:
            begin
                res.reg_write   = 1'b1;
                res.write_index = rt;
                res.write_value = rs_value | imm_zext;
            end
            OP_XORI:
            begin
                res.reg_write   = 1'b1;
                res.write_index = rt;
                res.write_value = rs_value ^ imm_zext;
            end
            OP_SLTI:
            begin
                res.reg_write   = 1'b1;
                res.write_index = rt;
                res.write_value = {31'd0, lt_imm};
            end
            OP_LUI:
            begin
                res.reg_write   = 1'b1;
                res.write_index = rt;
                res.write_value = {imm, 16'h0000};
            end
            OP_BEQ:
            begin
                if (rs_value == rt_value)
                begin
                    res.next_pc = br_target;
                end
            end
            OP_BNE:
            begin
                if (rs_value != rt_value)
                begin
                    res.next_pc = br_target;
                end
            end
            OP_BLEZ:
            begin
                if (rs_neg || rs_zero)
                begin
                    res.next_pc = br_target;
                end
            end
            OP_BGTZ:
            begin
                if (!rs_neg && !rs_zero)
                begin
                    res.next_pc = br_target;
                end
            end
            OP_REGIMM:
            begin
                if (rt == RT_BLTZ)
                begin
                    if (rs_neg)
                    begin
                        res.next_pc = br_target;
                    end
                end
                else if (rt == RT_BGEZ)
                begin
                    if (!rs_neg)
                    begin
                        res.next_pc = br_target;
                    end
                end
                else
                begin
                    res.unknown_op = 1'b1;
                end
            end
            OP_J:
            begin
                res.next_pc = j_target;
            end
            OP_JAL:
            begin
                res.reg_write   = 1'b1;
                res.write_index = REG_RA;
                res.write_value = seq_pc;
                res.next_pc     = j_target;
            end
            default:
            begin
                res.unknown_op = 1'b1;
            end
        endcase

        // Drop writes to register zero and clear unused write fields
        if (res.reg_write && (res.write_index == REG_ZERO))
        begin
            res.reg_write = 1'b0;
        end
        if (!res.reg_write)
        begin
            res.write_index = '0;
            res.write_value = '0;
        end
    end

endmodule

[hdl/mips_integer_execute_unit.sv]
// Top level of the MIPS integer execute unit: input stage, execute, result register.
//
//  Channel      Signals                                     Direction
//  instruction  in_valid / in_ready, instruction            in
//  result       out_valid / out_ready, next_pc, reg_write,  out
//               write_index, write_value, syscall_seen,
//               unknown_op
//  config       cfg_valid / cfg_ready, start_address        in
//
//  Sustains one instruction per clock while out_ready is high. Input transfers fill the
//  input registers; a result is registered on the outputs once the output side is free.
//  The loop that sets the rate is register file read, execute and write back of the
//  register file and PC, all in the same cycle between the input and result registers.
//  Reset clears the register file valid bits and loads the PC with 0x0040_0000;
//  the start address register resets to that same value with the core.
//  A stalled output holds its result; an empty input stage still takes one more item.
module mips_integer_execute_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mieu_pkg::word_t    instruction,
    output logic               out_valid,
    input  logic               out_ready,
    output mieu_pkg::word_t    next_pc,
    output logic               reg_write,
    output mieu_pkg::reg_idx_t write_index,
    output mieu_pkg::word_t    write_value,
    output logic               syscall_seen,
    output logic               unknown_op,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  mieu_pkg::word_t    start_address
);
    import mieu_pkg::*;

    logic         in_valid_reg;
    logic         in_valid_next;
    word_t        instr_reg;
    word_t        pc_reg;
    word_t        pc_next;
    word_t        start_addr_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    exec_result_t result_reg;
    exec_result_t exec_res;
    rf_write_t    rf_wr;
    word_t        rs_value;
    word_t        rt_value;
    logic         in_xfer;
    logic         advance;

    // Handshake control
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Register file write from the retiring instruction
    assign rf_wr.en    = advance && exec_res.reg_write;
    assign rf_wr.index = exec_res.write_index;
    assign rf_wr.value = exec_res.write_value;

    mieu_regfile u_regfile (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (in_xfer),
        .rs_idx   (instruction[25:21]),
        .rt_idx   (instruction[20:16]),
        .wr       (rf_wr),
        .rs_value (rs_value),
        .rt_value (rt_value)
    );

    mieu_exec u_exec (
        .instr    (instr_reg),
        .pc       (pc_reg),
        .rs_value (rs_value),
        .rt_value (rt_value),
        .res      (exec_res)
    );

    // Next state of the stage valids and the PC
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        pc_next = advance ? exec_res.next_pc : pc_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            pc_reg         <= START_ADDR_RESET;
            start_addr_reg <= START_ADDR_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            pc_reg        <= pc_next;
            if (cfg_valid && cfg_ready)
            begin
                start_addr_reg <= start_address;
            end
        end
    end

    // Payload: capture the instruction and the result
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            instr_reg <= instruction;
        end
        if (advance)
        begin
            result_reg <= exec_res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign next_pc      = result_reg.next_pc;
    assign reg_write    = result_reg.reg_write;
    assign write_index  = result_reg.write_index;
    assign write_value  = result_reg.write_value;
    assign syscall_seen = result_reg.syscall_seen;
    assign unknown_op   = result_reg.unknown_op;

endmodule

[hdl/mieu_checker.sv]
// Port-level checks on the MIPS integer execute unit, bound to the top level.
module mieu_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input mieu_pkg::word_t    next_pc,
    input logic               reg_write,
    input mieu_pkg::reg_idx_t write_index,
    input mieu_pkg::word_t    write_value,
    input logic               syscall_seen,
    input logic               unknown_op
);
    import mieu_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(next_pc) && $stable(write_value))
        else $error("result changed while stalled");

    // Never report a write to register zero
    a_no_zero_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reg_write |-> write_index != REG_ZERO)
        else $error("write to register zero reported");

    // Clear the write fields when no register is written
    a_clear_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !reg_write |-> write_index == '0 && write_value == '0)
        else $error("write fields not cleared");

    // Syscall and unknown instructions write nothing and exclude each other
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (syscall_seen || unknown_op) |-> !reg_write && !(syscall_seen && unknown_op))
        else $error("inconsistent status flags");

endmodule

bind mips_integer_execute_unit mieu_checker u_mieu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .next_pc      (next_pc),
    .reg_write    (reg_write),
    .write_index  (write_index),
    .write_value  (write_value),
    .syscall_seen (syscall_seen),
    .unknown_op   (unknown_op)
);
